FILE: hdl/utf8_strict_stream_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the strict UTF-8 stream decoder
// Shared concurrent forms of the checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_STRICT_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STRICT_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define UTF8SD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define UTF8SD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Payload types, status codes and range constants of the UTF-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] bytes_after;
    } utf8sd_in_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  status;
        logic        last_of_run;
    } utf8sd_out_t;

    // Results produced by one byte, handed from the decoder to the result queue
    typedef struct packed {
        logic [1:0]  num;
        utf8sd_out_t first;
        utf8sd_out_t second;
    } utf8sd_emit_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EOS     = 2'd2;

    localparam logic [20:0] CP_MIN_2B   = 21'h000080;
    localparam logic [20:0] CP_MIN_3B   = 21'h000800;
    localparam logic [20:0] CP_MIN_4B   = 21'h010000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [8:0]  FOUR_B_HIGH = 9'h110;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;

endpackage

`default_nettype wire

FILE: hdl/utf8sd_decode.sv
// ----------------------------------------------------------------------------
// utf8sd_decode
// Sequence state and per-byte decode: zero, one or two results per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_decode
    import utf8sd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         fire,
    input  wire utf8sd_in_t   item,
    output utf8sd_emit_t      emit
);

    logic [1:0]  trails_reg,  trails_next;
    logic [1:0]  seqlen_reg,  seqlen_next;
    logic [20:0] acc_reg,     acc_next;
    logic        failed_reg,  failed_next;
    logic        skip_reg,    skip_next;

    logic [7:0]  b;
    logic [1:0]  after;
    logic        trail;
    logic        ascii;
    logic [1:0]  lead_len;
    logic        lead_emit;
    logic        lead_eos;
    logic        lead_start;
    logic [20:0] lead_acc;
    utf8sd_out_t lead_out;
    logic [20:0] acc_shift;
    logic        fail_now;
    logic        seq_ok;

    assign b     = item.data_byte;
    assign after = item.bytes_after;
    assign trail = (b[7:6] == 2'b10);
    assign ascii = ~b[7];

    // Lead byte classification
    always_comb
    begin
        priority if (b >= 8'hF5) lead_len = 2'd0;
        else if (b >= 8'hF0)     lead_len = 2'd3;
        else if (b >= 8'hE0)     lead_len = 2'd2;
        else if (b >= 8'hC0)     lead_len = 2'd1;
        else                     lead_len = 2'd0;
    end

    assign lead_eos   = ~ascii && (lead_len != 2'd0) && (after < lead_len);
    assign lead_start = ~ascii && (lead_len != 2'd0) && (after >= lead_len);
    assign lead_emit  = ~lead_start;

    always_comb
    begin
        unique case (lead_len)
            2'd3:    lead_acc = {18'd0, b[2:0]};
            2'd2:    lead_acc = {17'd0, b[3:0]};
            default: lead_acc = {16'd0, b[4:0]};
        endcase
    end

    always_comb
    begin
        lead_out.last_of_run = 1'b1;
        priority if (ascii)
        begin
            lead_out.code_point = {13'd0, b};
            lead_out.status     = ST_OK;
        end
        else if (lead_eos)
        begin
            lead_out.code_point = '0;
            lead_out.status     = ST_EOS;
        end
        else
        begin
            lead_out.code_point = '0;
            lead_out.status     = ST_INVALID;
        end
    end

    // Continuation byte accumulate and range checks
    assign acc_shift = {acc_reg[14:0], b[5:0]};
    assign fail_now  = failed_reg
                     | ((seqlen_reg == 2'd3) && (trails_reg == 2'd3)
                        && (acc_shift >= {12'd0, FOUR_B_HIGH}));

    always_comb
    begin
        unique case (seqlen_reg)
            2'd3:    seq_ok = (acc_shift >= CP_MIN_4B) && (acc_shift <= CP_MAX);
            2'd2:    seq_ok = (acc_shift >= CP_MIN_3B)
                              && ((acc_shift < SURR_LO) || (acc_shift > SURR_HI));
            default: seq_ok = (acc_shift >= CP_MIN_2B);
        endcase
        seq_ok = seq_ok && ~fail_now;
    end

    always_comb
    begin
        trails_next = trails_reg;
        seqlen_next = seqlen_reg;
        acc_next    = acc_reg;
        failed_next = failed_reg;
        skip_next   = skip_reg;
        emit.num    = 2'd0;
        emit.first  = lead_out;
        emit.second = lead_out;

        if (trails_reg != 2'd0)
        begin
            if (trail)
            begin
                trails_next = trails_reg - 2'd1;
                if (trails_reg == 2'd1)
                begin
                    emit.num = 2'd1;
                    emit.first.last_of_run = 1'b1;
                    if (seq_ok)
                    begin
                        emit.first.code_point = acc_shift;
                        emit.first.status     = ST_OK;
                    end
                    else
                    begin
                        emit.first.code_point = '0;
                        emit.first.status     = ST_INVALID;
                        skip_next             = (after != 2'd0);
                    end
                    seqlen_next = 2'd0;
                    acc_next    = '0;
                    failed_next = 1'b0;
                end
                else
                begin
                    acc_next    = acc_shift;
                    failed_next = fail_now;
                end
            end
            else
            begin
                // Broken sequence: report it, then decode this byte as a lead
                emit.first.code_point  = '0;
                emit.first.status      = ST_INVALID;
                emit.first.last_of_run = ~lead_emit;
                emit.num    = lead_emit ? 2'd2 : 2'd1;
                trails_next = 2'd0;
                seqlen_next = 2'd0;
                acc_next    = '0;
                failed_next = 1'b0;
                if (lead_start)
                begin
                    trails_next = lead_len;
                    seqlen_next = lead_len;
                    acc_next    = lead_acc;
                end
                if (lead_eos)
                    skip_next = (after != 2'd0);
            end
        end
        else if (skip_reg && trail)
        begin
            if (after == 2'd0)
                skip_next = 1'b0;
        end
        else
        begin
            skip_next = 1'b0;
            emit.num  = {1'b0, lead_emit};
            if (lead_start)
            begin
                trails_next = lead_len;
                seqlen_next = lead_len;
                acc_next    = lead_acc;
                failed_next = 1'b0;
            end
            if (lead_eos)
                skip_next = (after != 2'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trails_reg <= '0;
            seqlen_reg <= '0;
            acc_reg    <= '0;
            failed_reg <= 1'b0;
            skip_reg   <= 1'b0;
        end
        else if (fire)
        begin
            trails_reg <= trails_next;
            seqlen_reg <= seqlen_next;
            acc_reg    <= acc_next;
            failed_reg <= failed_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/utf8sd_result_fifo.sv
// ----------------------------------------------------------------------------
// utf8sd_result_fifo
// Small result queue: up to two pushes per cycle, one transfer out per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sd_result_fifo
    import utf8sd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    push_num,
    input  wire utf8sd_out_t   push_first,
    input  wire utf8sd_out_t   push_second,
    output logic               space_ok,
    output logic               cp_valid,
    input  wire logic          cp_ready,
    output utf8sd_out_t        cp_item
);

    utf8sd_out_t           mem_reg [RQ_DEPTH];
    logic [RQ_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [RQ_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [RQ_AW:0]        count_reg,  count_next;
    logic                  pop;

    assign cp_valid = (count_reg != '0);
    assign cp_item  = mem_reg[rd_ptr_reg];
    assign pop      = cp_valid & cp_ready;
    assign space_ok = (count_reg <= (RQ_AW+1)'(RQ_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + RQ_AW'(push_num);
    assign rd_ptr_next = rd_ptr_reg + RQ_AW'(pop);
    assign count_next  = count_reg + (RQ_AW+1)'(push_num) - (RQ_AW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
            mem_reg[wr_ptr_reg] <= push_first;
        if (push_num == 2'd2)
            mem_reg[wr_ptr_reg + RQ_AW'(1)] <= push_second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/utf8_strict_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_strict_stream_decoder_unit
// Strict UTF-8 byte stream to code point decoder, one byte per cycle unless cp stalls.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                          | Carries
//  --------+----------------------------------+---------------------------------
//  byte    | byte_valid, byte_ready, byte_item| data_byte, bytes_after
//  cp      | cp_valid, cp_ready, cp_item      | code_point, status, last_of_run
//
//  Each byte is registered in the input register and decoded from there into
//  the result queue, which registers the result before it appears on cp.
//  Sustained rate is one byte per cycle while cp keeps up; a byte that yields
//  two results (broken sequence, then a new lead) takes an extra cp transfer.
//  Reset clears the sequence state, the input valid flag and queue pointers.
//  A stall on cp fills the queue; decode holds while fewer than two slots
//  are free, and byte_ready drops once the input register is also held.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_strict_stream_decoder_unit
    import utf8sd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_ready,
    input  wire utf8sd_in_t   byte_item,
    output logic              cp_valid,
    input  wire logic         cp_ready,
    output utf8sd_out_t       cp_item
);

    utf8sd_in_t   item_reg;
    logic         item_valid_reg, item_valid_next;
    logic         space_ok;
    logic         fire;
    logic         take;
    logic [1:0]   push_num;
    utf8sd_emit_t emit;

    // Decode the held byte once the queue can absorb its worst case of two
    // results; the input register refills in the same cycle.
    assign fire       = item_valid_reg & space_ok;
    assign byte_ready = ~item_valid_reg | fire;
    assign take       = byte_valid & byte_ready;
    assign push_num   = fire ? emit.num : 2'd0;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
            item_valid_next = 1'b1;
        else if (fire)
            item_valid_next = 1'b0;
    end

    // Hold the byte payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= byte_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    utf8sd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .emit  (emit)
    );

    utf8sd_result_fifo u_result_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_num    (push_num),
        .push_first  (emit.first),
        .push_second (emit.second),
        .space_ok    (space_ok),
        .cp_valid    (cp_valid),
        .cp_ready    (cp_ready),
        .cp_item     (cp_item)
    );

endmodule

`default_nettype wire

FILE: hdl/utf8sd_checker.sv
// ----------------------------------------------------------------------------
// utf8sd_checker
// Port-level checks on the decoder result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_strict_stream_decoder_unit_macros.svh"

module utf8sd_checker
    import utf8sd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    input  wire logic         byte_ready,
    input  wire logic         cp_valid,
    input  wire logic         cp_ready,
    input  wire utf8sd_out_t  cp_item
);

    logic cp_ok_range;
    logic cp_stall;
    logic cp_mid;
    logic cp_head;
    logic cp_ok_item;
    logic byte_seen_reg;

    assign cp_ok_range = (cp_item.code_point <= CP_MAX)
                       && ((cp_item.code_point < SURR_LO) || (cp_item.code_point > SURR_HI));
    assign cp_stall    = cp_valid && !cp_ready;
    assign cp_mid      = cp_valid && !cp_item.last_of_run;
    assign cp_head     = cp_mid && cp_ready;
    assign cp_ok_item  = cp_valid && (cp_item.status == ST_OK);

    // Note the first byte transfer since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_seen_reg <= 1'b0;
        else if (byte_valid && byte_ready)
            byte_seen_reg <= 1'b1;
    end

    // Hold a stalled result
    `UTF8SD_ASSERT_NEXT(a_cp_hold, cp_stall, cp_valid && $stable(cp_item), "stalled result moved")

    // A run of two results is delivered without a gap
    `UTF8SD_ASSERT_NEXT(a_run_cont, cp_head, cp_valid, "second result of a run missing")

    // Only a broken sequence report can open a two-result run
    `UTF8SD_ASSERT_NOW(a_run_head, cp_mid, cp_item.status == ST_INVALID, "run head not invalid")

    // Decoded values are Unicode scalar values
    `UTF8SD_ASSERT_NOW(a_cp_scalar, cp_ok_item, cp_ok_range, "decoded value out of range")

    // A result needs a byte transfer that has already passed the input register
    `UTF8SD_ASSERT_NEXT(a_latency, !byte_seen_reg, !cp_valid, "result earlier than two cycles")

endmodule

bind utf8_strict_stream_decoder_unit utf8sd_checker u_checker (.*);

`default_nettype wire

FILE: verif/utf8_strict_stream_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// utf8_strict_stream_decoder_unit_tb
// Drives byte streams into the strict UTF-8 decoder and scores every code
// point, invalid and truncation result against an in-bench decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_strict_stream_decoder_unit_tb
    import utf8sd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1800;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int SETTLE       = 16;
    localparam int PRINT_LIMIT  = 40;

    // ------------------------------------------------------------------------
    // Scoreboard: a byte-level decoder that keeps its own sequence state and
    // queues the results each accepted byte must produce, in order.
    // ------------------------------------------------------------------------
    class utf8_decode_scoreboard;
        logic [1:0]  trails_left;
        logic [1:0]  seq_len;
        logic [20:0] acc;
        logic        seq_failed;
        logic        skipping;
        utf8sd_out_t pending_code_points[$];
        int          errors;

        function new();
            trails_left = '0;
            seq_len     = '0;
            acc         = '0;
            seq_failed  = 1'b0;
            skipping    = 1'b0;
            errors      = 0;
        endfunction

        task report_mismatch(string what);
            if (errors < PRINT_LIMIT)
                $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        function void expect_result(logic [20:0] cp, logic [1:0] st);
            utf8sd_out_t r;
            r.code_point  = cp;
            r.status      = st;
            r.last_of_run = 1'b0;
            pending_code_points.push_back(r);
        endfunction

        // Start a sequence on a lead byte, or settle the byte at once.
        function void open_sequence(logic [7:0] b, logic [1:0] after);
            logic [1:0] len;
            if (b < 8'h80) begin
                expect_result({13'd0, b}, ST_OK);
                return;
            end
            if (b >= 8'hF5)      len = 2'd0;
            else if (b >= 8'hF0) len = 2'd3;
            else if (b >= 8'hE0) len = 2'd2;
            else if (b >= 8'hC0) len = 2'd1;
            else                 len = 2'd0;
            if (len == 2'd0) begin
                expect_result('0, ST_INVALID);
                return;
            end
            // Too few bytes left in the stream: flag it, drop what follows
            if (after < len) begin
                skipping = (after != 2'd0);
                expect_result('0, ST_EOS);
                return;
            end
            trails_left = len;
            seq_len     = len;
            seq_failed  = 1'b0;
            case (len)
                2'd3:    acc = {18'd0, b[2:0]};
                2'd2:    acc = {17'd0, b[3:0]};
                default: acc = {16'd0, b[4:0]};
            endcase
        endfunction

        function void note_byte(utf8sd_in_t item);
            logic [7:0]  b;
            logic [1:0]  after;
            logic        trail;
            logic        ok;
            int          n_queued;
            utf8sd_out_t tail;
            b        = item.data_byte;
            after    = item.bytes_after;
            trail    = (b[7:6] == 2'b10);
            n_queued = pending_code_points.size();
            if (trails_left != 2'd0) begin
                if (trail) begin
                    acc = {acc[14:0], b[5:0]};
                    // A four-byte form past 10FFFF shows after its first trail
                    if (seq_len == 2'd3 && trails_left == 2'd3 && acc >= 21'(FOUR_B_HIGH))
                        seq_failed = 1'b1;
                    trails_left = trails_left - 2'd1;
                    if (trails_left == 2'd0) begin
                        if (seq_failed)
                            ok = 1'b0;
                        else if (seq_len == 2'd3)
                            ok = (acc >= CP_MIN_4B) && (acc <= CP_MAX);
                        else if (seq_len == 2'd2)
                            ok = (acc >= CP_MIN_3B) && (acc < SURR_LO || acc > SURR_HI);
                        else
                            ok = (acc >= CP_MIN_2B);
                        if (ok) begin
                            expect_result(acc, ST_OK);
                        end else begin
                            expect_result('0, ST_INVALID);
                            skipping = (after != 2'd0);
                        end
                        seq_len    = '0;
                        acc        = '0;
                        seq_failed = 1'b0;
                    end
                end else begin
                    // Broken sequence: reject it, then decode this byte afresh
                    expect_result('0, ST_INVALID);
                    trails_left = '0;
                    seq_len     = '0;
                    acc         = '0;
                    seq_failed  = 1'b0;
                    open_sequence(b, after);
                end
            end else if (skipping) begin
                if (trail) begin
                    if (after == 2'd0)
                        skipping = 1'b0;
                end else begin
                    skipping = 1'b0;
                    open_sequence(b, after);
                end
            end else begin
                open_sequence(b, after);
            end
            // Mark the final result this byte produced
            if (pending_code_points.size() > n_queued) begin
                tail = pending_code_points.pop_back();
                tail.last_of_run = 1'b1;
                pending_code_points.push_back(tail);
            end
        endfunction

        task check_result(utf8sd_out_t got);
            utf8sd_out_t want;
            if (pending_code_points.size() == 0) begin
                report_mismatch($sformatf("unexpected result cp=%06h status=%0d last=%0d",
                                          got.code_point, got.status, got.last_of_run));
                return;
            end
            want = pending_code_points.pop_front();
            if (got.code_point !== want.code_point)
                report_mismatch($sformatf("code_point %06h, expected %06h",
                                          got.code_point, want.code_point));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %0d, expected %0d",
                                          got.last_of_run, want.last_of_run));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    utf8sd_in_t  byte_item = '0;
    logic        cp_valid;
    logic        cp_ready = 1'b0;
    utf8sd_out_t cp_item;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    utf8_strict_stream_decoder_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .cp_valid   (cp_valid),
        .cp_ready   (cp_ready),
        .cp_item    (cp_item)
    );

    utf8_decode_scoreboard sb = new();

    // Traffic phase, advanced by the sender:
    //   0 - sender idles 30%, receiver stalls 87%
    //   1 - sender idles 87%, receiver stalls 30%
    //   2 - no idling on either side (after one long receiver hold-off)
    int phase = 0;

    // ------------------------------------------------------------------------
    // Byte plan: whole streams, each byte tagged with the count of bytes that
    // follow it in its stream (saturated at 3).
    // ------------------------------------------------------------------------
    utf8sd_in_t byte_plan[$];
    logic [7:0] stream_buf[$];

    // Close the current stream; scramble gives every byte a random count
    // so that inconsistent counts inside a sequence are exercised too.
    function automatic void flush_stream(bit scramble);
        int left;
        for (int k = 0; k < stream_buf.size(); k++) begin
            utf8sd_in_t it;
            left = stream_buf.size() - 1 - k;
            it.data_byte = stream_buf[k];
            if (scramble)
                it.bytes_after = 2'($urandom_range(0, 3));
            else
                it.bytes_after = (left > 3) ? 2'd3 : 2'(left);
            byte_plan.push_back(it);
        end
        stream_buf.delete();
    endfunction

    // Encode cp in an nbytes form (overlong when cp is small) and append
    // the first keep bytes of it.
    function automatic void put_scalar(logic [20:0] cp, int nbytes, int keep);
        logic [7:0] enc [4];
        enc = '{default: 8'h00};
        case (nbytes)
            1: enc[0] = {1'b0, cp[6:0]};
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int k = 0; k < keep; k++)
            stream_buf.push_back(enc[k]);
    endfunction

    // About half well-formed scalars with random content; the rest overlong
    // forms, surrogates, values past 10FFFF, cut sequences and noise.
    function automatic void add_random_stream();
        int tokens;
        int pick;
        int n;
        tokens = $urandom_range(1, 6);
        for (int t = 0; t < tokens; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                n = $urandom_range(1, 4);
                case (n)
                    1:       put_scalar(21'($urandom_range(0, 'h7F)), 1, 1);
                    2:       put_scalar(21'($urandom_range('h80, 'h7FF)), 2, 2);
                    3:       put_scalar(21'($urandom_range('h800, 'hFFFF)), 3, 3);
                    default: put_scalar(21'($urandom_range('h10000, 'h10FFFF)), 4, 4);
                endcase
            end else if (pick < 60) begin
                n = $urandom_range(2, 4);
                case (n)
                    2:       put_scalar(21'($urandom_range(0, 'h7F)), 2, 2);
                    3:       put_scalar(21'($urandom_range(0, 'h7FF)), 3, 3);
                    default: put_scalar(21'($urandom_range(0, 'hFFFF)), 4, 4);
                endcase
            end else if (pick < 66) begin
                put_scalar(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
            end else if (pick < 72) begin
                put_scalar(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
            end else if (pick < 80) begin
                n = $urandom_range(2, 4);
                put_scalar(21'($urandom_range(0, 'h1FFFFF)), n, $urandom_range(1, n - 1));
            end else if (pick < 88) begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    stream_buf.push_back(8'($urandom_range('h80, 'hBF)));
            end else begin
                stream_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Cut the tail of some streams short so a lead runs out of bytes
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(2, 4);
            put_scalar(21'($urandom_range(0, 'h10FFFF)), n, $urandom_range(1, n - 1));
        end
        flush_stream($urandom_range(0, 99) < 8);
    endfunction

    function automatic void build_plan();
        // Directed: ASCII extremes, shortest two-byte scalar, overlong form,
        // surrogate, largest scalar, value past 10FFFF with a dropped trail,
        // invalid lead, stray continuation, lead short of bytes, and a
        // sequence broken by an ASCII byte.
        stream_buf = '{8'h00, 8'h7F};                     flush_stream(1'b0);
        stream_buf = '{8'hC2, 8'h80};                     flush_stream(1'b0);
        stream_buf = '{8'hC0, 8'h80};                     flush_stream(1'b0);
        stream_buf = '{8'hED, 8'hA0, 8'h80};              flush_stream(1'b0);
        stream_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};       flush_stream(1'b0);
        stream_buf = '{8'hF4, 8'h90, 8'h80, 8'h80, 8'h80}; flush_stream(1'b0);
        stream_buf = '{8'hF5};                            flush_stream(1'b0);
        stream_buf = '{8'h80};                            flush_stream(1'b0);
        stream_buf = '{8'hE2, 8'h82};                     flush_stream(1'b0);
        stream_buf = '{8'hC3, 8'h41};                     flush_stream(1'b0);
        while (byte_plan.size() < RANDOM_BYTES + 24)
            add_random_stream();
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offer each planned byte, hold it until the transfer, and idle
    // between bytes at the rate of the current phase.
    // ------------------------------------------------------------------------
    task automatic send_bytes();
        int total;
        int idle_pct;
        total = byte_plan.size();
        for (int i = 0; i < total; i++) begin
            if (i < total / 3)
                phase = 0;
            else if (i < (2 * total) / 3)
                phase = 1;
            else
                phase = 2;
            idle_pct = (phase == 0) ? 30 : (phase == 1) ? 87 : 0;
            while ($urandom_range(0, 99) < idle_pct) begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
            byte_valid <= 1'b1;
            byte_item  <= byte_plan[i];
            @(posedge clk);
            while (!byte_ready)
                @(posedge clk);
        end
        byte_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall at the rate of the current phase. On entering the last
    // phase, hold ready low for a long stretch so the result queue and the
    // input register fill and byte_ready drops while bytes are still offered.
    // ------------------------------------------------------------------------
    initial
    begin
        bit held_off;
        int stall_pct;
        held_off = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (phase == 2 && !held_off) begin
                held_off = 1'b1;
                cp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall_pct = (phase == 0) ? 87 : (phase == 1) ? 30 : 0;
                cp_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: score every transfer on both channels at the clock edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (byte_valid && byte_ready)
                sb.note_byte(byte_item);
            if (cp_valid && cp_ready)
                sb.check_result(cp_item);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int guard;
        build_plan();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_bytes();
        // Drain: wait for every expected result, then keep clocking so
        // any stray extra result still shows up.
        guard = 0;
        while (sb.pending_code_points.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
        if (sb.pending_code_points.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived",
                                         sb.pending_code_points.size()));
        if (sb.errors == 0)
            $display("utf8_strict_stream_decoder_unit test passed");
        else
            $display("utf8_strict_stream_decoder_unit test failed");
        $finish;
    end

    // Watchdog: end a hung run
    initial
    begin
        #2_000_000;
        $display("utf8_strict_stream_decoder_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
